@@ rtl/wft_pkg.sv @@
// ----------------------------------------------------------------------------
// wft_pkg: shared types and constants of the Wiegand frame transmitter
// Payload structs of both channels, format codes, timing defaults.
// ----------------------------------------------------------------------------
package wft_pkg;

    localparam logic [0:0] CMD_TICK  = 1'b0;
    localparam logic [0:0] CMD_START = 1'b1;

    localparam logic [1:0] FMT_26 = 2'd0;
    localparam logic [1:0] FMT_34 = 2'd1;
    localparam logic [1:0] FMT_66 = 2'd2;

    localparam logic [0:0] REG_PULSE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_PULSE_PERIOD = 1'b1;

    localparam logic [7:0] WIDTH_RESET  = 8'd10;
    localparam logic [7:0] PERIOD_RESET = 8'd160;
    localparam logic [7:0] WIDTH_MIN    = 8'd4;
    localparam logic [7:0] WIDTH_MAX    = 8'd20;
    localparam logic [7:0] PERIOD_MIN   = 8'd80;

    typedef struct packed {
        logic [0:0]  command;
        logic [1:0]  frame_format;
        logic [63:0] payload;
    } in_item_t;

    typedef struct packed {
        logic data0_line;
        logic data1_line;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } out_item_t;

    typedef struct packed {
        logic [7:0] eff_width;
        logic [7:0] eff_gap;
    } timing_t;

    // payload length of a format; code three counts as the 66-bit format
    function automatic logic [6:0] payload_len(input logic [1:0] fmt);
        logic [6:0] n;
        case (fmt)
            FMT_26:  n = 7'd24;
            FMT_34:  n = 7'd32;
            default: n = 7'd64;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/wiegand_frame_transmitter_top.sv @@
// ----------------------------------------------------------------------------
// wiegand_frame_transmitter_top: Wiegand 26/34/66-bit frame transmitter
// Timing registers, frame sequencer and result register.
// ----------------------------------------------------------------------------
// Each request (a tick or a frame start) yields one result with the data0 and
// data1 line levels and the busy, done and rejected flags. A request is taken
// when s_valid and s_ready are both high: the sequencer state and the result
// register update on the same edge, so one request per clock is sustained while
// m_ready stays high; s_ready drops only while a result waits in the output
// register and m_ready is low. Write the timing registers through
// cfg_we/cfg_index/cfg_wdata while no request is in flight.
module wiegand_frame_transmitter_top
    import wft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    timing_t   timing;
    out_item_t result;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      take;

    assign s_ready = !out_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    wft_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .timing    (timing)
    );

    wft_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_take (take),
        .item      (s_data),
        .timing    (timing),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_lines_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.data0_line || m_data.data1_line))
        else $error("both Wiegand lines low");

    a_pulse_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !(m_data.data0_line && m_data.data1_line)) |-> m_data.busy_res)
        else $error("pulse outside a frame");

    a_done_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> (!m_data.busy_res && !m_data.start_rejected))
        else $error("frame_done while still busy");

    a_reject_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.start_rejected) |-> m_data.busy_res)
        else $error("start rejected while idle");

endmodule

@@ rtl/wft_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// wft_cfg_regs: timing registers
// Holds pulse width and period and derives the pulse and gap lengths in use.
// ----------------------------------------------------------------------------
module wft_cfg_regs
    import wft_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output timing_t    timing
);

    logic [7:0] width_reg;
    logic [7:0] period_reg;
    logic [7:0] per_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PULSE_WIDTH:  width_reg  <= cfg_wdata;
                REG_PULSE_PERIOD: period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < WIDTH_MIN || width_reg > WIDTH_MAX) begin
            timing.eff_width = WIDTH_RESET;
        end else begin
            timing.eff_width = width_reg;
        end
        per_used = (period_reg < PERIOD_MIN) ? PERIOD_RESET : period_reg;
        timing.eff_gap = per_used - timing.eff_width;
    end

endmodule

@@ rtl/wft_frame_core.sv @@
// ----------------------------------------------------------------------------
// wft_frame_core: frame sequencer
// Advances the bit and tick counters per request and forms the line levels.
// ----------------------------------------------------------------------------
module wft_frame_core
    import wft_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_take,
    input  in_item_t  item,
    input  timing_t   timing,
    output out_item_t result
);

    logic [63:0] shift_reg,  shift_next;
    logic        lead_reg,   lead_next;
    logic        trail_reg,  trail_next;
    logic [1:0]  fmt_reg,    fmt_next;
    logic [6:0]  pos_reg,    pos_next;
    logic        pulse_reg,  pulse_next;
    logic [7:0]  tick_reg,   tick_next;
    logic        send_reg,   send_next;

    logic [7:0]  tick_dec;
    logic [6:0]  pos_inc;
    logic [6:0]  n_next;
    logic [6:0]  bit_dist;
    logic        cur_bit;
    logic        done;
    logic        rejected;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            lead_reg  <= 1'b0;
            trail_reg <= 1'b0;
            fmt_reg   <= '0;
            pos_reg   <= '0;
            pulse_reg <= 1'b0;
            tick_reg  <= '0;
            send_reg  <= 1'b0;
        end else if (item_take) begin
            shift_reg <= shift_next;
            lead_reg  <= lead_next;
            trail_reg <= trail_next;
            fmt_reg   <= fmt_next;
            pos_reg   <= pos_next;
            pulse_reg <= pulse_next;
            tick_reg  <= tick_next;
            send_reg  <= send_next;
        end
    end

    always_comb begin
        shift_next = shift_reg;
        lead_next  = lead_reg;
        trail_next = trail_reg;
        fmt_next   = fmt_reg;
        pos_next   = pos_reg;
        pulse_next = pulse_reg;
        tick_next  = tick_reg;
        send_next  = send_reg;
        done       = 1'b0;
        rejected   = 1'b0;
        tick_dec   = tick_reg - 8'd1;
        pos_inc    = pos_reg + 7'd1;

        if (item.command == CMD_START) begin
            if (send_reg) begin
                rejected = 1'b1;
            end else begin
                fmt_next = item.frame_format;
                case (item.frame_format)
                    FMT_26: begin
                        shift_next = {40'd0, item.payload[23:0]};
                        lead_next  = ^item.payload[23:12];
                        trail_next = ~^item.payload[11:0];
                    end
                    FMT_34: begin
                        shift_next = {32'd0, item.payload[31:0]};
                        lead_next  = ^item.payload[31:16];
                        trail_next = ~^item.payload[15:0];
                    end
                    default: begin
                        shift_next = item.payload;
                        lead_next  = ^item.payload[63:32];
                        trail_next = ~^item.payload[31:0];
                    end
                endcase
                pos_next   = '0;
                pulse_next = 1'b1;
                tick_next  = timing.eff_width;
                send_next  = 1'b1;
            end
        end else if (send_reg) begin
            tick_next = tick_dec;
            if (tick_dec == 8'd0) begin
                if (pulse_reg) begin
                    pulse_next = 1'b0;
                    tick_next  = timing.eff_gap;
                end else if (pos_inc >= payload_len(fmt_reg) + 7'd2) begin
                    // last gap over: close the frame
                    send_next = 1'b0;
                    pos_next  = '0;
                    done      = 1'b1;
                end else begin
                    pos_next   = pos_inc;
                    pulse_next = 1'b1;
                    tick_next  = timing.eff_width;
                end
            end
        end

        // bit on the wire, from the updated state
        n_next   = payload_len(fmt_next);
        bit_dist = n_next - pos_next;
        if (pos_next == 7'd0) begin
            cur_bit = lead_next;
        end else if (pos_next > n_next) begin
            cur_bit = trail_next;
        end else begin
            cur_bit = shift_next[bit_dist[5:0]];
        end

        result.data0_line     = !(send_next && pulse_next && !cur_bit);
        result.data1_line     = !(send_next && pulse_next && cur_bit);
        result.busy_res       = send_next;
        result.frame_done     = done;
        result.start_rejected = rejected;
    end

endmodule
